[rtl/bse_pkg.sv]
// package for beam_stress_envelope: payload structs and shared constants
// no dependencies
`default_nettype none
package bse_pkg;
  localparam int unsigned ForceWidth  = 32;
  localparam int unsigned StressWidth = 48;
  localparam int unsigned CfgWidth    = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned NavWidth    = 47;

  localparam logic [CfgIdxWidth-1:0] RegArea = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegIy   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegIz   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegEyMx = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegEyMn = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegEzMx = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegEzMn = 3'd6;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] axial_force;
    logic signed [31:0] torsion;
    logic signed [31:0] shear_y;
    logic signed [31:0] shear_z;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
  } in_item_t;

  typedef struct packed {
    logic        [46:0] navier_stress;
    logic signed [31:0] max_axial;
    logic signed [31:0] min_axial;
    logic        [31:0] max_torsion;
    logic        [31:0] min_torsion;
    logic        [31:0] max_shear;
    logic        [31:0] min_shear;
    logic        [31:0] max_moment;
    logic        [31:0] min_moment;
    logic        [46:0] max_navier;
    logic        [46:0] min_navier;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/bse_core.sv]
// bse_core: sequencer computing terms, corners and resultants for one item
// depends on bse_pkg; bit-serial multiply, divide and square root
`default_nettype none
module bse_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [bse_pkg::ForceWidth-1:0] n_i,
  input  wire logic signed [bse_pkg::ForceWidth-1:0] vy_i,
  input  wire logic signed [bse_pkg::ForceWidth-1:0] vz_i,
  input  wire logic signed [bse_pkg::ForceWidth-1:0] my_i,
  input  wire logic signed [bse_pkg::ForceWidth-1:0] mz_i,
  input  wire logic [31:0]                           area_i,
  input  wire logic [31:0]                           iy_i,
  input  wire logic [31:0]                           iz_i,
  input  wire logic [31:0]                           eymx_i,
  input  wire logic [31:0]                           eymn_i,
  input  wire logic [31:0]                           ezmx_i,
  input  wire logic [31:0]                           ezmn_i,
  output logic                                       done_o,
  output logic [46:0]                                navier_o,
  output logic [31:0]                                shear_o,
  output logic [31:0]                                moment_o
);
  import bse_pkg::*;

  localparam int unsigned MagW = ForceWidth;
  localparam logic [63:0] TermCap = 64'd1 << 61;
  localparam logic [63:0] StressSat = (64'd1 << (StressWidth - 1)) - 64'd1;

  // job steps
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul  = 4'd1;
  localparam logic [3:0] StDiv  = 4'd2;
  localparam logic [3:0] StSq   = 4'd3;
  localparam logic [3:0] StRt   = 4'd4;
  localparam logic [3:0] StFin  = 4'd5;
  localparam logic [3:0] StDone = 4'd6;

  logic [3:0]  st_q, st_d;
  logic [3:0]  job_q, job_d;     // term index 0..4, then squares of vy, vz, my, mz 5..8
  logic [6:0]  cnt_q, cnt_d;
  // shared shift/add datapath
  logic [63:0] acc_q, acc_d;     // product / dividend / radicand
  logic [63:0] mc_q, mc_d;       // multiplicand
  logic [MagW-1:0] mp_q, mp_d;   // multiplier bits
  logic        ovf_q, ovf_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] sq0_q, sq0_d;
  logic        neg_q, neg_d;
  logic signed [63:0] t_q [5];
  logic signed [63:0] t_d [5];
  logic [31:0] res_q [2];
  logic [31:0] res_d [2];
  logic [46:0] nav_q, nav_d;
  logic        done_q, done_d;

  logic signed [ForceWidth-1:0] x_sel;
  logic [63:0] k_sel;
  logic [31:0] d_sel;
  logic [MagW-1:0] x_mag;
  logic [64:0] sum65;
  logic [64:0] rem_sh;
  logic [63:0] qv;
  logic [63:0] sq_sum;
  logic [64:0] sq_tmp;
  logic signed [65:0] c_sum [4];
  logic [65:0] c_mag [4];
  logic [46:0] c_sat [4];
  logic [46:0] best;

  always_comb begin
    unique case (job_q)
      4'd0: begin x_sel = n_i;  k_sel = 64'd65536;    d_sel = area_i; end
      4'd1: begin x_sel = mz_i; k_sel = {32'd0, ezmx_i}; d_sel = iz_i; end
      4'd2: begin x_sel = mz_i; k_sel = {32'd0, ezmn_i}; d_sel = iz_i; end
      4'd3: begin x_sel = my_i; k_sel = {32'd0, eymx_i}; d_sel = iy_i; end
      4'd4: begin x_sel = my_i; k_sel = {32'd0, eymn_i}; d_sel = iy_i; end
      4'd5: begin x_sel = vy_i; k_sel = '0; d_sel = '0; end
      4'd6: begin x_sel = vz_i; k_sel = '0; d_sel = '0; end
      4'd7: begin x_sel = my_i; k_sel = '0; d_sel = '0; end
      4'd8: begin x_sel = mz_i; k_sel = '0; d_sel = '0; end
      default: begin x_sel = my_i; k_sel = '0; d_sel = '0; end
    endcase
    x_mag = x_sel[ForceWidth-1] ? MagW'(-x_sel) : MagW'(x_sel);
  end

  always_comb begin
    st_d = st_q; job_d = job_q; cnt_d = cnt_q; acc_d = acc_q; mc_d = mc_q;
    mp_d = mp_q; ovf_d = ovf_q; rem_d = rem_q; quo_d = quo_q; sq0_d = sq0_q;
    neg_d = neg_q; nav_d = nav_q; done_d = 1'b0;
    for (int i = 0; i < 5; i++) t_d[i] = t_q[i];
    for (int i = 0; i < 2; i++) res_d[i] = res_q[i];
    sum65 = '0; rem_sh = '0; qv = '0; sq_sum = '0; sq_tmp = '0; best = '0;
    for (int i = 0; i < 4; i++) begin
      c_sum[i] = 66'(t_q[0]) + 66'((i < 2) ? t_q[1] : -t_q[2])
               + 66'((i % 2 == 0) ? t_q[3] : -t_q[4]);
      c_mag[i] = c_sum[i][65] ? 66'(-c_sum[i]) : 66'(c_sum[i]);
      c_sat[i] = (c_mag[i] > 66'(StressSat)) ? StressSat[46:0] : c_mag[i][46:0];
    end
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = StMul; job_d = 4'd0; cnt_d = '0;
        end
      end
      StMul: begin
        // one multiplier bit per cycle, saturating at 64 bits
        if (cnt_q == 7'd0) begin
          mp_d = x_mag; neg_d = x_sel[ForceWidth-1];
          mc_d = (job_q >= 4'd5) ? 64'(x_mag) : k_sel;
          acc_d = '0; ovf_d = 1'b0; cnt_d = 7'd1;
        end else begin
          if (mp_q[0]) begin
            sum65 = {1'b0, acc_q} + {1'b0, mc_q};
            acc_d = sum65[63:0];
            if (sum65[64]) ovf_d = 1'b1;
          end
          if (mp_q[MagW-1:1] != '0 && mc_q[63]) ovf_d = 1'b1;
          mc_d = mc_q << 1;
          mp_d = mp_q >> 1;
          if (cnt_q == 7'(MagW)) begin
            cnt_d = '0;
            if (job_q >= 4'd5) begin
              st_d = StSq;
            end else begin
              st_d = StDiv;
            end
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      StDiv: begin
        // restoring division, one quotient bit per cycle
        if (cnt_q == 7'd0) begin
          if (ovf_q) acc_d = '1;
          rem_d = '0; cnt_d = 7'd1;
        end else begin
          rem_sh = {rem_q[63:0], acc_q[63]};
          acc_d = acc_q << 1;
          if (rem_sh >= {33'd0, d_sel}) begin
            rem_d = rem_sh - {33'd0, d_sel};
            quo_d = {quo_q[62:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[62:0], 1'b0};
          end
          if (cnt_q == 7'd64) begin
            qv = (d_sel == 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo_d;
            if (qv > TermCap) qv = TermCap;
            t_d[job_q[2:0]] = neg_q ? -$signed(qv) : $signed(qv);
            cnt_d = '0;
            if (job_q == 4'd4) begin
              st_d = StMul; job_d = 4'd5;
            end else begin
              st_d = StMul; job_d = job_q + 4'd1;
            end
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      StSq: begin
        // squares of a resultant pair
        if (job_q == 4'd5 || job_q == 4'd7) begin
          sq0_d = ovf_q ? '1 : acc_q;
          job_d = job_q + 4'd1;
          st_d = StMul;
        end else begin
          sq_tmp = {1'b0, sq0_q} + {1'b0, (ovf_q ? 64'hFFFF_FFFF_FFFF_FFFF : acc_q)};
          acc_d = sq_tmp[64] ? '1 : sq_tmp[63:0];
          rem_d = '0; quo_d = '0; cnt_d = '0;
          st_d = StRt;
        end
      end
      StRt: begin
        // digit-by-digit square root, one result bit per cycle
        rem_sh = {rem_q[62:0], acc_q[63:62]};
        acc_d = acc_q << 2;
        sq_sum = {quo_q[61:0], 2'b01};
        if (rem_sh >= {1'b0, sq_sum}) begin
          rem_d = rem_sh - {1'b0, sq_sum};
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[62:0], 1'b0};
        end
        if (cnt_q == 7'd31) begin
          cnt_d = '0;
          if (job_q == 4'd6) begin
            res_d[0] = quo_d[31:0];
            st_d = StMul; job_d = 4'd7;
          end else begin
            res_d[1] = quo_d[31:0];
            st_d = StFin;
          end
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      StFin: begin
        best = c_sat[0];
        for (int i = 1; i < 4; i++) if (c_sat[i] > best) best = c_sat[i];
        nav_d = best;
        st_d = StDone;
      end
      StDone: begin
        done_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; job_q <= '0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; job_q <= job_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mc_q <= mc_d; mp_q <= mp_d; ovf_q <= ovf_d;
    rem_q <= rem_d; quo_q <= quo_d; sq0_q <= sq0_d; neg_q <= neg_d;
    nav_q <= nav_d;
    for (int i = 0; i < 5; i++) t_q[i] <= t_d[i];
    for (int i = 0; i < 2; i++) res_q[i] <= res_d[i];
  end

  assign done_o   = done_q;
  assign navier_o = nav_q;
  assign shear_o  = res_q[0];
  assign moment_o = res_q[1];
endmodule
`default_nettype wire

[rtl/beam_stress_envelope.sv]
// beam_stress_envelope top level: handshake, section registers, envelope
// depends on bse_pkg and bse_core
`default_nettype none
// One item at a time. A sample item's result reaches the output register after the five
// divided terms, the shear and moment resultants, and the steps that pick the largest
// corner, flag completion and load the output register; the next item can be accepted in
// the cycle after that. The bit-serial multiplier, divider and square-root unit is shared
// by all terms. A clear item's result lands once the output register is free, and the next
// item can follow in the cycle after that. A finished result waits while the output
// register is stalled, and the input stays stalled meanwhile.
module beam_stress_envelope (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire bse_pkg::in_item_t                 in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output bse_pkg::out_item_t                     out_item_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [bse_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [bse_pkg::CfgWidth-1:0]      cfg_data_i
);
  import bse_pkg::*;

  logic [31:0] area_q, iy_q, iz_q, eymx_q, eymn_q, ezmx_q, ezmn_q;
  logic busy_q, clr_q, ovld_q, fin_q;
  in_item_t itm_q;
  out_item_t out_q;
  logic done, start, fin, out_free, land_clr, land_done;
  logic [46:0] nav;
  logic [31:0] shr, mom, tmag;
  logic signed [31:0] na;

  assign in_stall_o = busy_q;
  assign start = in_valid_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= 32'd65536; iy_q <= 32'd65536; iz_q <= 32'd65536;
      eymx_q <= '0; eymn_q <= '0; ezmx_q <= '0; ezmn_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegArea: area_q <= cfg_data_i;
        RegIy:   iy_q <= cfg_data_i;
        RegIz:   iz_q <= cfg_data_i;
        RegEyMx: eymx_q <= cfg_data_i;
        RegEyMn: eymn_q <= cfg_data_i;
        RegEzMx: ezmx_q <= cfg_data_i;
        RegEzMn: ezmn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) if (start) itm_q <= in_item_i;

  bse_core u_core (
    .clk_i, .rst_ni,
    .start_i (start && !in_item_i.mode),
    .n_i (ForceWidth'(itm_q.axial_force)), .vy_i (ForceWidth'(itm_q.shear_y)),
    .vz_i (ForceWidth'(itm_q.shear_z)), .my_i (ForceWidth'(itm_q.moment_y)),
    .mz_i (ForceWidth'(itm_q.moment_z)),
    .area_i (area_q), .iy_i (iy_q), .iz_i (iz_q), .eymx_i (eymx_q),
    .eymn_i (eymn_q), .ezmx_i (ezmx_q), .ezmn_i (ezmn_q),
    .done_o (done), .navier_o (nav), .shear_o (shr), .moment_o (mom)
  );

  assign na = itm_q.axial_force;
  assign tmag = itm_q.torsion[31] ? 32'(-itm_q.torsion) : itm_q.torsion;

  // a finished result is kept pending until the output register is free
  assign fin       = done || fin_q;
  assign out_free  = !(ovld_q && out_stall_i);
  assign land_clr  = clr_q && out_free;
  assign land_done = fin && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; clr_q <= 1'b0; ovld_q <= 1'b0; fin_q <= 1'b0;
      out_q.navier_stress <= '0;
      out_q.max_axial <= 32'sh8000_0000; out_q.min_axial <= 32'sh7FFF_FFFF;
      out_q.max_torsion <= '0; out_q.min_torsion <= '1;
      out_q.max_shear <= '0; out_q.min_shear <= '1;
      out_q.max_moment <= '0; out_q.min_moment <= '1;
      out_q.max_navier <= '0; out_q.min_navier <= '1;
    end else begin
      ovld_q <= land_clr || land_done || (ovld_q && out_stall_i);
      busy_q <= start || (busy_q && !(land_clr || land_done));
      clr_q  <= (start && in_item_i.mode) || (clr_q && !out_free);
      fin_q  <= fin && !out_free;
      if (land_clr) begin
        out_q.navier_stress <= '0;
        out_q.max_axial <= 32'sh8000_0000; out_q.min_axial <= 32'sh7FFF_FFFF;
        out_q.max_torsion <= '0; out_q.min_torsion <= '1;
        out_q.max_shear <= '0; out_q.min_shear <= '1;
        out_q.max_moment <= '0; out_q.min_moment <= '1;
        out_q.max_navier <= '0; out_q.min_navier <= '1;
      end else if (land_done) begin
        out_q.navier_stress <= nav;
        if (na > out_q.max_axial) out_q.max_axial <= na;
        if (na < out_q.min_axial) out_q.min_axial <= na;
        if (tmag > out_q.max_torsion) out_q.max_torsion <= tmag;
        if (tmag < out_q.min_torsion) out_q.min_torsion <= tmag;
        if (shr > out_q.max_shear) out_q.max_shear <= shr;
        if (shr < out_q.min_shear) out_q.min_shear <= shr;
        if (mom > out_q.max_moment) out_q.max_moment <= mom;
        if (mom < out_q.min_moment) out_q.min_moment <= mom;
        if (nav > out_q.max_navier) out_q.max_navier <= nav;
        if (nav < out_q.min_navier) out_q.min_navier <= nav;
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign out_item_o  = out_q;
endmodule
`default_nettype wire
